// ===== hw/rtl/ritp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the radix integer text parser.
// No dependencies; used by ritp_front, ritp_queue, ritp_back and the top level.
package ritp_pkg;

    localparam int CHAR_BITS  = 8;
    localparam int BASE_BITS  = 6;
    localparam int OUT_BITS   = 64;

    localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CHAR_VT    = 8'h0B;
    localparam logic [CHAR_BITS-1:0] CHAR_FF    = 8'h0C;
    localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_X  = 8'h58;
    localparam logic [CHAR_BITS-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LO_X  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CHAR_LO_Z  = 8'h7A;

    localparam logic [BASE_BITS-1:0] DIGIT_ALPHA_OFS = 6'd10;

    typedef enum logic [1:0] {
        PH_WS,
        PH_SIGNED,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic                 last;
        logic                 is_nul;
        logic                 is_ws;
        logic                 is_plus;
        logic                 is_minus;
        logic                 is_zero;
        logic                 is_x;
        logic                 is_alnum;
        logic [BASE_BITS-1:0] digit;
        logic [BASE_BITS-1:0] radix;
    } item_t;

endpackage

// ===== hw/rtl/ritp_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the radix register and classifies each incoming byte.
// Depends on ritp_pkg.
module ritp_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ritp_pkg::BASE_BITS-1:0] cfg_data,
    input  logic [ritp_pkg::CHAR_BITS-1:0] char_code,
    input  logic                           last,
    output ritp_pkg::item_t                item
);

    logic [ritp_pkg::BASE_BITS-1:0] radix_reg;
    logic [ritp_pkg::BASE_BITS-1:0] radix_next;
    logic [ritp_pkg::CHAR_BITS-1:0] ofs;

    assign cfg_ready = 1'b1;

    always_comb begin
        radix_next = radix_reg;
        if (cfg_valid) begin
            radix_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= ritp_pkg::BASE_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    always_comb begin
        item.last     = last;
        item.radix    = radix_reg;
        item.is_nul   = (char_code == ritp_pkg::CHAR_NUL);
        item.is_ws    = (char_code == ritp_pkg::CHAR_SPACE) || (char_code == ritp_pkg::CHAR_TAB)
                     || (char_code == ritp_pkg::CHAR_LF) || (char_code == ritp_pkg::CHAR_CR)
                     || (char_code == ritp_pkg::CHAR_FF) || (char_code == ritp_pkg::CHAR_VT);
        item.is_plus  = (char_code == ritp_pkg::CHAR_PLUS);
        item.is_minus = (char_code == ritp_pkg::CHAR_MINUS);
        item.is_zero  = (char_code == ritp_pkg::CHAR_ZERO);
        item.is_x     = (char_code == ritp_pkg::CHAR_LO_X) || (char_code == ritp_pkg::CHAR_UP_X);
        item.is_alnum = 1'b0;
        ofs           = '0;
        if (char_code >= ritp_pkg::CHAR_ZERO && char_code <= ritp_pkg::CHAR_NINE) begin
            item.is_alnum = 1'b1;
            ofs           = char_code - ritp_pkg::CHAR_ZERO;
        end else if (char_code >= ritp_pkg::CHAR_LO_A && char_code <= ritp_pkg::CHAR_LO_Z) begin
            item.is_alnum = 1'b1;
            ofs           = char_code - ritp_pkg::CHAR_LO_A
                          + ritp_pkg::CHAR_BITS'(ritp_pkg::DIGIT_ALPHA_OFS);
        end else if (char_code >= ritp_pkg::CHAR_UP_A && char_code <= ritp_pkg::CHAR_UP_Z) begin
            item.is_alnum = 1'b1;
            ofs           = char_code - ritp_pkg::CHAR_UP_A
                          + ritp_pkg::CHAR_BITS'(ritp_pkg::DIGIT_ALPHA_OFS);
        end
        item.digit = ofs[ritp_pkg::BASE_BITS-1:0];
    end

endmodule

// ===== hw/rtl/ritp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified bytes between front and back end.
// Depends on ritp_pkg.
module ritp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ritp_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ritp_pkg::item_t rd_item
);

    ritp_pkg::item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hw/rtl/ritp_back.sv =====
`timescale 1ns / 1ps
// Back end: parse state machine, multiply-add accumulator and result register.
// Depends on ritp_pkg.
module ritp_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ritp_pkg::item_t                 item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ritp_pkg::OUT_BITS-1:0]   out_value,
    output logic                            out_is_number,
    output logic                            out_saturated
);

    localparam int PROD_BITS = VALUE_BITS + ritp_pkg::BASE_BITS;
    localparam logic [VALUE_BITS-1:0] MAG_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    ritp_pkg::phase_t               phase_reg, phase_next;
    logic                           neg_reg, neg_next;
    logic [VALUE_BITS-1:0]          mag_reg, mag_next;
    logic                           seen_reg, seen_next;
    logic                           lzp_reg, lzp_next;
    logic [ritp_pkg::BASE_BITS-1:0] base_reg, base_next;
    logic                           clamp_reg, clamp_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_neg_reg, out_neg_next;
    logic [VALUE_BITS-1:0]          out_mag_reg, out_mag_next;
    logic                           out_num_reg, out_num_next;
    logic                           out_sat_reg, out_sat_next;

    logic                           take;
    logic                           do_digit;
    logic [ritp_pkg::BASE_BITS-1:0] cur_base, eff_base;
    logic                           lzp_cur;
    logic [VALUE_BITS-1:0]          mag_in;
    logic [PROD_BITS-1:0]           prod;
    logic                           base_ok, fin_num;
    logic [ritp_pkg::OUT_BITS-1:0]  ext;

    function automatic logic valid_base(input logic [ritp_pkg::BASE_BITS-1:0] b);
        return (b >= ritp_pkg::BASE_MIN) && (b <= ritp_pkg::BASE_MAX);
    endfunction

    function automatic logic prefix_base(input logic [ritp_pkg::BASE_BITS-1:0] b);
        return (b == ritp_pkg::BASE_AUTO) || (b == ritp_pkg::BASE_DEC)
            || (b == ritp_pkg::BASE_HEX);
    endfunction

    assign in_ready = !item.last || !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign prod     = PROD_BITS'(mag_in) * PROD_BITS'(eff_base) + PROD_BITS'(item.digit);

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        seen_next  = seen_reg;
        lzp_next   = lzp_reg;
        base_next  = base_reg;
        clamp_next = clamp_reg;
        do_digit   = 1'b0;
        mag_in     = mag_reg;
        cur_base   = (phase_reg == ritp_pkg::PH_WS) ? item.radix : base_reg;
        lzp_cur    = (phase_reg == ritp_pkg::PH_WS) ? 1'b0 : lzp_reg;
        eff_base   = (cur_base == ritp_pkg::BASE_AUTO) ? ritp_pkg::BASE_DEC : cur_base;

        case (phase_reg)
            ritp_pkg::PH_WS: begin
                base_next = item.radix;
                if (item.is_nul) begin
                    phase_next = ritp_pkg::PH_DONE;
                end else if (item.is_ws) begin
                    phase_next = ritp_pkg::PH_WS;
                end else if (item.is_plus) begin
                    phase_next = ritp_pkg::PH_SIGNED;
                end else if (item.is_minus) begin
                    neg_next   = 1'b1;
                    phase_next = ritp_pkg::PH_SIGNED;
                end else if (item.is_zero && prefix_base(cur_base)) begin
                    lzp_next   = 1'b1;
                    phase_next = ritp_pkg::PH_SIGNED;
                end else begin
                    base_next = eff_base;
                    do_digit  = 1'b1;
                end
            end
            ritp_pkg::PH_SIGNED: begin
                if (lzp_cur) begin
                    lzp_next = 1'b0;
                    if (item.is_x) begin
                        base_next  = ritp_pkg::BASE_HEX;
                        phase_next = ritp_pkg::PH_DIGITS;
                    end else begin
                        seen_next = 1'b1;
                        mag_in    = '0;
                        mag_next  = '0;
                        base_next = eff_base;
                        do_digit  = 1'b1;
                    end
                end else if (item.is_zero && prefix_base(cur_base)) begin
                    lzp_next = 1'b1;
                end else begin
                    base_next = eff_base;
                    do_digit  = 1'b1;
                end
            end
            ritp_pkg::PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
                phase_next = ritp_pkg::PH_DONE;
            end
        endcase

        if (do_digit) begin
            phase_next = ritp_pkg::PH_DIGITS;
            if (item.is_nul || !valid_base(eff_base) || !item.is_alnum
                    || item.digit >= eff_base) begin
                phase_next = ritp_pkg::PH_DONE;
            end else begin
                seen_next = 1'b1;
                if (prod > PROD_BITS'(MAG_MAX)) begin
                    mag_next   = MAG_MAX;
                    clamp_next = 1'b1;
                end else begin
                    mag_next = prod[VALUE_BITS-1:0];
                end
            end
        end

        base_ok = valid_base(base_next) || prefix_base(base_next);
        fin_num = (seen_next || lzp_next) && base_ok;

        out_valid_next = out_valid_reg && !out_ready;
        out_neg_next   = out_neg_reg;
        out_mag_next   = out_mag_reg;
        out_num_next   = out_num_reg;
        out_sat_next   = out_sat_reg;

        if (take && item.last) begin
            out_valid_next = 1'b1;
            out_neg_next   = fin_num && neg_next;
            out_mag_next   = (fin_num && seen_next) ? mag_next : '0;
            out_num_next   = fin_num;
            out_sat_next   = fin_num && clamp_next;
            phase_next     = ritp_pkg::PH_WS;
            neg_next       = 1'b0;
            mag_next       = '0;
            seen_next      = 1'b0;
            lzp_next       = 1'b0;
            base_next      = ritp_pkg::BASE_AUTO;
            clamp_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ritp_pkg::PH_WS;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            seen_reg      <= 1'b0;
            lzp_reg       <= 1'b0;
            base_reg      <= ritp_pkg::BASE_AUTO;
            clamp_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                mag_reg   <= mag_next;
                seen_reg  <= seen_next;
                lzp_reg   <= lzp_next;
                base_reg  <= base_next;
                clamp_reg <= clamp_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_neg_reg <= out_neg_next;
        out_mag_reg <= out_mag_next;
        out_num_reg <= out_num_next;
        out_sat_reg <= out_sat_next;
    end

    assign ext           = ritp_pkg::OUT_BITS'(out_mag_reg);
    assign out_valid     = out_valid_reg;
    assign out_value     = out_neg_reg ? (ritp_pkg::OUT_BITS'(0) - ext) : ext;
    assign out_is_number = out_num_reg;
    assign out_saturated = out_sat_reg;

endmodule

// ===== hw/rtl/radix_integer_text_parser_core.sv =====
`timescale 1ns / 1ps
// Radix integer text parser, top level: front classifier, queue, back end.
// Takes one byte per cycle while s_tready is high; the back end does one multiply-add per byte.
// A result is registered in the output register once the back end takes its last byte from the queue.
// Throughput: 1 byte per cycle, set by the accumulator update, while m_tready does not stall a final byte.
// Reset: aresetn low clears the queue, parse state and output valid; radix returns to 10.
module radix_integer_text_parser_core #(
    parameter int VALUE_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,   // radix
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // value
    output logic [1:0]  m_tuser     // saturated (bit 1), is_number (bit 0)
);

    ritp_pkg::item_t front_item;
    ritp_pkg::item_t back_item;
    logic            back_valid;
    logic            back_ready;
    logic            is_number;
    logic            saturated;

    ritp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .char_code (s_tdata),
        .last      (s_tlast),
        .item      (front_item)
    );

    ritp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_item  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_item  (back_item)
    );

    ritp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (back_valid),
        .in_ready      (back_ready),
        .item          (back_item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_value     (m_tdata),
        .out_is_number (is_number),
        .out_saturated (saturated)
    );

    assign m_tuser = {saturated, is_number};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for radix_integer_text_parser_core: directed strings, then random text traffic.
// Depends on ritp_pkg and the core; a built-in parser model predicts each result.
module tb_top;
    import ritp_pkg::*;

    localparam int          GAP_MAX      = 18;
    localparam int          QUIET_MAX    = 4000;
    localparam int          CFG_PAUSE    = 4;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          RANDOM_CHARS = 1600;
    localparam int          USER_NUM     = 0;
    localparam int          USER_SAT     = 1;
    localparam logic [63:0] MAG_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } idle_mode_t;

    typedef struct {
        logic [63:0] value;
        logic        is_number;
        logic        saturated;
    } parse_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data  = BASE_RESET;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = CHAR_NUL;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    // parser model state
    logic [5:0]  radix_reg    = BASE_RESET;
    phase_t      parse_phase  = PH_WS;
    logic        is_neg       = 1'b0;
    logic [63:0] mag_acc      = '0;
    logic        got_digit    = 1'b0;
    logic        zero_pending = 1'b0;
    logic [5:0]  cur_base     = BASE_AUTO;
    logic        clamped      = 1'b0;

    parse_result_t expected_results[$];
    logic [7:0]    text_buf[$];

    idle_mode_t tx_idle = IDLE_LIGHT;
    idle_mode_t rx_idle = IDLE_LIGHT;
    int ready_hold      = 0;
    int quiet_cycles    = 0;
    int chars_sent      = 0;
    int strings_done    = 0;
    int results_checked = 0;
    int radix_writes    = 0;
    int sat_expected    = 0;
    int nan_expected    = 0;
    int error_count     = 0;

    radix_integer_text_parser_core #(
        .VALUE_BITS(64)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial forever #1 aclk = ~aclk;

    function automatic int draw_wait(idle_mode_t mode);
        int n;
        n = 0;
        if (mode == IDLE_HEAVY) begin
            n = $urandom_range(0, GAP_MAX);
        end else if (mode == IDLE_LIGHT && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(0, GAP_MAX);
        end
        return n;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR ||
               c == CHAR_FF || c == CHAR_VT;
    endfunction

    function automatic bit base_ok(logic [5:0] b);
        return b >= BASE_MIN && b <= BASE_MAX;
    endfunction

    function automatic bit prefix_ok(logic [5:0] b);
        return b == BASE_AUTO || b == BASE_DEC || b == BASE_HEX;
    endfunction

    function automatic int char_digit(logic [7:0] c, logic [5:0] base);
        int d;
        d = -1;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = int'(c - CHAR_ZERO);
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            d = int'(c - CHAR_LO_A) + int'(DIGIT_ALPHA_OFS);
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            d = int'(c - CHAR_UP_A) + int'(DIGIT_ALPHA_OFS);
        end
        if (d >= int'(base)) begin
            d = -1;
        end
        return d;
    endfunction

    function automatic void clear_parse();
        parse_phase  = PH_WS;
        is_neg       = 1'b0;
        mag_acc      = '0;
        got_digit    = 1'b0;
        zero_pending = 1'b0;
        cur_base     = BASE_AUTO;
        clamped      = 1'b0;
    endfunction

    function automatic void accum_digit(logic [7:0] c);
        int d;
        d = char_digit(c, cur_base);
        if (c == CHAR_NUL || !base_ok(cur_base) || d < 0) begin
            parse_phase = PH_DONE;
        end else begin
            got_digit = 1'b1;
            if (mag_acc > (MAG_MAX - 64'(d)) / 64'(cur_base)) begin
                mag_acc = MAG_MAX;
                clamped = 1'b1;
            end else begin
                mag_acc = mag_acc * 64'(cur_base) + 64'(d);
            end
        end
    endfunction

    function automatic void after_sign(logic [7:0] c);
        if (zero_pending) begin
            zero_pending = 1'b0;
            parse_phase  = PH_DIGITS;
            if (c == CHAR_LO_X || c == CHAR_UP_X) begin
                cur_base = BASE_HEX;
            end else begin
                got_digit = 1'b1;
                mag_acc   = '0;
                if (cur_base == BASE_AUTO) begin
                    cur_base = BASE_DEC;
                end
                accum_digit(c);
            end
        end else if (c == CHAR_ZERO && prefix_ok(cur_base)) begin
            zero_pending = 1'b1;
        end else begin
            if (cur_base == BASE_AUTO) begin
                cur_base = BASE_DEC;
            end
            parse_phase = PH_DIGITS;
            accum_digit(c);
        end
    endfunction

    function automatic void predict_char(logic [7:0] c, logic lst);
        parse_result_t res;
        logic [63:0]   mag;
        case (parse_phase)
            PH_WS: begin
                cur_base = radix_reg;
                if (c == CHAR_NUL) begin
                    parse_phase = PH_DONE;
                end else if (is_blank(c)) begin
                    parse_phase = PH_WS;
                end else if (c == CHAR_PLUS) begin
                    parse_phase = PH_SIGNED;
                end else if (c == CHAR_MINUS) begin
                    is_neg      = 1'b1;
                    parse_phase = PH_SIGNED;
                end else begin
                    parse_phase = PH_SIGNED;
                    after_sign(c);
                end
            end
            PH_SIGNED: after_sign(c);
            PH_DIGITS: accum_digit(c);
            default: ;
        endcase
        if (lst) begin
            res.is_number = got_digit || zero_pending;
            mag = (zero_pending && !got_digit) ? 64'd0 : mag_acc;
            if (!base_ok(cur_base) && !prefix_ok(cur_base)) begin
                res.is_number = 1'b0;
            end
            if (res.is_number) begin
                res.value     = is_neg ? 64'd0 - mag : mag;
                res.saturated = clamped;
            end else begin
                res.value     = '0;
                res.saturated = 1'b0;
                nan_expected++;
            end
            if (res.saturated) begin
                sat_expected++;
            end
            expected_results.push_back(res);
            clear_parse();
        end
    endfunction

    function automatic void check_result();
        parse_result_t want;
        results_checked++;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, actual value %0d is_number %0b saturated %0b",
                     $time, $signed(m_tdata), m_tuser[USER_NUM], m_tuser[USER_SAT]);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (m_tdata !== want.value) begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, $signed(want.value), $signed(m_tdata));
                error_count++;
            end
            if (m_tuser[USER_NUM] !== want.is_number) begin
                $display("%0t: is_number mismatch, expected %0b, actual %0b",
                         $time, want.is_number, m_tuser[USER_NUM]);
                error_count++;
            end
            if (m_tuser[USER_SAT] !== want.saturated) begin
                $display("%0t: saturated mismatch, expected %0b, actual %0b",
                         $time, want.saturated, m_tuser[USER_SAT]);
                error_count++;
            end
        end
    endfunction

    // predict on every accepted input transaction
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_char(s_tdata, s_tlast);
        end
    end

    // result sink: check, then hold ready low for a random stall
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result();
                ready_hold = draw_wait(rx_idle);
            end else if (ready_hold > 0) begin
                ready_hold--;
            end
            m_tready <= (ready_hold == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_MAX);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(logic [7:0] c, logic lst);
        int gap;
        gap = draw_wait(tx_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        if (lst) begin
            strings_done++;
        end
    endtask

    task automatic put_byte(logic [7:0] c);
        text_buf.push_back(c);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    task automatic send_string(string s);
        put_text(s);
        send_buffer();
    endtask

    // drop valid, wait for all results, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_checked < strings_done) @(posedge aclk);
        repeat (CFG_PAUSE) @(posedge aclk);
    endtask

    task automatic write_radix(logic [5:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radix_reg = value;
        radix_writes++;
    endtask

    function automatic logic [7:0] digit_char(int v);
        if (v < int'(DIGIT_ALPHA_OFS)) begin
            return 8'(int'(CHAR_ZERO) + v);
        end
        if ($urandom_range(0, 1) == 0) begin
            return 8'(int'(CHAR_LO_A) + v - int'(DIGIT_ALPHA_OFS));
        end
        return 8'(int'(CHAR_UP_A) + v - int'(DIGIT_ALPHA_OFS));
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = CHAR_SPACE;
            1: c = CHAR_TAB;
            2: c = CHAR_LF;
            3: c = CHAR_CR;
            4: c = CHAR_FF;
            default: c = CHAR_VT;
        endcase
        return c;
    endfunction

    task automatic build_random_text();
        int         n;
        logic [5:0] gen_base;
        text_buf.delete();
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 8);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) put_byte(pick_blank());
            case ($urandom_range(0, 3))
                0: put_byte(CHAR_PLUS);
                1: put_byte(CHAR_MINUS);
                default: ;
            endcase
            gen_base = radix_reg;
            if ($urandom_range(0, 3) == 0) begin
                put_byte(CHAR_ZERO);
                put_byte($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
                gen_base = BASE_HEX;
            end
            if (!base_ok(gen_base)) begin
                gen_base = BASE_DEC;
            end
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(14, 66) : $urandom_range(0, 6);
            repeat (n) put_byte(digit_char($urandom_range(0, int'(gen_base) - 1)));
            case ($urandom_range(0, 5))
                0: put_byte(8'($urandom_range(0, 255)));
                1: begin
                    put_byte(CHAR_NUL);
                    put_byte(digit_char($urandom_range(0, 9)));
                end
                default: ;
            endcase
        end
        if (text_buf.size() == 0) begin
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_default_radix();
        send_string("42");
        send_string("-0");
        send_string("0");
        send_string("+");
        send_string("0x1F");
        send_string("9z");
    endtask

    task automatic test_blanks_and_nul();
        put_byte(CHAR_SPACE);
        put_byte(CHAR_TAB);
        put_byte(CHAR_LF);
        put_byte(CHAR_CR);
        put_byte(CHAR_FF);
        put_byte(CHAR_VT);
        put_text("-7");
        send_buffer();
        put_byte(CHAR_SPACE);
        put_byte(CHAR_TAB);
        put_byte(CHAR_VT);
        send_buffer();
        send_char(CHAR_NUL, 1'b1);
        put_text("1");
        put_byte(CHAR_NUL);
        put_text("5");
        send_buffer();
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_prefix_forms();
        write_radix(BASE_HEX);
        send_string("0x");
        send_string("-0Xff");
        write_radix(BASE_AUTO);
        send_string("077");
        send_string("0xA");
        write_radix(BASE_MIN);
        send_string("0x1");
    endtask

    task automatic test_saturation();
        write_radix(BASE_MAX);
        repeat (13) put_byte(CHAR_LO_Z);
        send_buffer();
        put_byte(CHAR_MINUS);
        repeat (13) put_byte(CHAR_UP_Z);
        send_buffer();
        repeat (12) put_byte(CHAR_LO_Z);
        send_buffer();
        write_radix(BASE_DEC);
        send_string("9223372036854775807");
    endtask

    task automatic test_invalid_radix();
        write_radix(6'd1);
        send_string("1");
        write_radix(6'd63);
        send_string("0x5");
        write_radix(6'd37);
        send_string("12");
    endtask

    task automatic test_random_traffic();
        logic [5:0] radix_list[$];
        int         phase_chars;
        int         target;
        radix_list = {BASE_AUTO, BASE_MIN, BASE_MAX, BASE_HEX, BASE_DEC, 6'd1, 6'd63, 6'd37};
        repeat (4) radix_list.push_back(6'($urandom_range(0, 63)));
        target = RANDOM_CHARS / radix_list.size();
        foreach (radix_list[i]) begin
            write_radix(radix_list[i]);
            if (i == 0) begin
                tx_idle = IDLE_NONE;
                rx_idle = IDLE_NONE;
            end else if (i == 1) begin
                tx_idle = IDLE_HEAVY;
                rx_idle = IDLE_HEAVY;
            end else begin
                tx_idle = idle_mode_t'($urandom_range(0, 2));
                rx_idle = idle_mode_t'($urandom_range(0, 2));
            end
            phase_chars = 0;
            while (phase_chars < target) begin
                build_random_text();
                phase_chars += text_buf.size();
                send_buffer();
            end
        end
    endtask

    task automatic finish_run();
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d bytes in %0d strings over %0d radix writes, %0d results checked.",
                 chars_sent, strings_done, radix_writes, results_checked);
        $display("Of those, %0d saturated and %0d not-a-number; %0d mismatches.",
                 sat_expected, nan_expected, error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_radix();
        test_blanks_and_nul();
        test_prefix_forms();
        test_saturation();
        test_invalid_radix();
        test_random_traffic();
        finish_run();
    end

endmodule
